// ----- sv/edf_pkg.sv -----
// edf_pkg: widths, reset values, register indexes and shared types of the
// EMA deadband filter.
// No dependencies.
`timescale 1ns / 1ps

package edf_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRAC_BITS     = 16;
  localparam int AVG_BITS      = SAMPLE_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS   = 17;
  localparam int WEIGHT_SHIFT  = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = (WEIGHT_BITS > SAMPLE_BITS) ? WEIGHT_BITS : SAMPLE_BITS;

  // Weight of 1.0 in Q1.16
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE     = WEIGHT_BITS'(1) << WEIGHT_SHIFT;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET   = WEIGHT_BITS'(13107);
  localparam logic [SAMPLE_BITS-1:0] DEADBAND_RESET = SAMPLE_BITS'(4);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WEIGHT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_DEADBAND = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [SAMPLE_BITS-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] sample;
  } in_word_t;

endpackage

// ----- sv/edf_cfg_regs.sv -----
// edf_cfg_regs: smoothing weight and deadband registers behind the write port.
// Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_cfg_regs
  import edf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WEIGHT:   cfg_d.weight   = cfg_wdata_i[WEIGHT_BITS-1:0];
        CFG_IDX_DEADBAND: cfg_d.deadband = cfg_wdata_i[SAMPLE_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight   <= WEIGHT_RESET;
      cfg_q.deadband <= DEADBAND_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/edf_in_stage.sv -----
// edf_in_stage: input register for one sample word with valid/ready handshake.
// Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_in_stage
  import edf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   take_i,
  output in_word_t               word_o
);

  logic                   valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   accept;

  // Free, or emptied by the core in this cycle
  assign sample_ready_o = !valid_q || take_i;
  assign accept         = sample_valid_i && sample_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

  assign word_o.valid  = valid_q;
  assign word_o.sample = sample_q;

endmodule

// ----- sv/edf_ema_core.sv -----
// edf_ema_core: moving-average update, rounding, deadband hold and the
// result register. Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_ema_core
  import edf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  in_word_t               word_i,
  output logic                   take_o,
  output logic                   filtered_valid_o,
  input  logic                   filtered_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_o
);

  localparam int DELTA_BITS = AVG_BITS + 1;
  localparam int PROD_BITS  = WEIGHT_BITS + 1 + DELTA_BITS;
  localparam logic [AVG_BITS:0] HALF_LSB = (AVG_BITS + 1)'(1) << (FRAC_BITS - 1);

  logic                         out_valid_q;
  logic [AVG_BITS-1:0]          avg_q, avg_d;
  logic [SAMPLE_BITS-1:0]       held_q, held_d;
  logic                         primed_q;

  logic [WEIGHT_BITS-1:0]       w_sat;
  logic [AVG_BITS-1:0]          target;
  logic signed [DELTA_BITS-1:0] delta;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  step;
  logic signed [PROD_BITS-1:0]  sum;
  logic [AVG_BITS-1:0]          avg_upd;
  logic [AVG_BITS:0]            rnd;
  logic [SAMPLE_BITS-1:0]       rounded;
  logic [SAMPLE_BITS-1:0]       gap;

  assign take_o = word_i.valid && (!out_valid_q || filtered_ready_i);

  // new = avg + ((w * (target - avg)) >>> 16), same as the weighted sum form
  always_comb begin
    w_sat   = (cfg_i.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_i.weight;
    target  = {word_i.sample, {FRAC_BITS{1'b0}}};
    delta   = $signed({1'b0, target}) - $signed({1'b0, avg_q});
    prod    = $signed({1'b0, w_sat}) * delta;
    step    = prod >>> WEIGHT_SHIFT;
    sum     = $signed({{(PROD_BITS - AVG_BITS){1'b0}}, avg_q}) + step;
    avg_upd = sum[AVG_BITS-1:0];
    // round half up; a carry out of the integer part wraps
    rnd     = {1'b0, avg_upd} + HALF_LSB;
    rounded = rnd[AVG_BITS-1:FRAC_BITS];
    gap     = (rounded >= held_q) ? (rounded - held_q) : (held_q - rounded);

    if (!primed_q) begin
      avg_d  = target;
      held_d = word_i.sample;
    end else begin
      avg_d  = avg_upd;
      held_d = (gap >= cfg_i.deadband) ? rounded : held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      held_q      <= '0;
      primed_q    <= 1'b0;
    end else begin
      if (take_o) begin
        out_valid_q <= 1'b1;
        avg_q       <= avg_d;
        held_q      <= held_d;
        primed_q    <= 1'b1;
      end else if (filtered_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held value changes only when a new word loads, so it doubles as payload
  assign filtered_valid_o = out_valid_q;
  assign filtered_o       = held_q;

endmodule

// ----- sv/ema_deadband_filter_unit.sv -----
// ema_deadband_filter_unit: EMA filter with deadband on the held output.
// Depends on edf_pkg, edf_cfg_regs, edf_in_stage, edf_ema_core.
//
// Usage:
//   Sample channel (sample_valid_i/sample_ready_o/sample_i) takes one 10-bit
//   ADC word; filtered channel (filtered_valid_o/filtered_ready_i/filtered_o)
//   returns one 10-bit held value per sample, in order.
//   Path: input register, then average/result registers, then filtered_o;
//   one word per cycle sustained while filtered_ready_i is high. The rate is set by the
//   average feedback loop: one 18x27 multiply, add, round and deadband compare
//   between the input register and the average/result registers.
//   Configuration: cfg_we_i writes index 0 (smoothing weight, Q1.16, values
//   above 1.0 act as 1.0) or index 1 (deadband). Write only while idle.
//   Reset: weight 13107, deadband 4, average and held value zero. The first
//   sample after reset loads the average and the output directly.
//   Stall: a pending result holds while filtered_ready_i is low; one more
//   sample is buffered in the input register, then sample_ready_o drops.
`timescale 1ns / 1ps

module ema_deadband_filter_unit
  import edf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sample_valid_i,
  output logic                     sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     filtered_valid_o,
  input  logic                     filtered_ready_i,
  output logic [SAMPLE_BITS-1:0]   filtered_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cfg_t     cfg;
  in_word_t word;
  logic     take;

  edf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  edf_in_stage u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .take_i         (take),
    .word_o         (word)
  );

  edf_ema_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .word_i           (word),
    .take_o           (take),
    .filtered_valid_o (filtered_valid_o),
    .filtered_ready_i (filtered_ready_i),
    .filtered_o       (filtered_o)
  );

endmodule

// ----- sv/edf_checker.sv -----
// edf_checker: port-level assertions for ema_deadband_filter_unit, bound
// to the top level. Depends on edf_pkg.
`timescale 1ns / 1ps

module edf_checker
  import edf_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     sample_valid_i,
  input logic                     sample_ready_o,
  input logic                     filtered_valid_o,
  input logic                     filtered_ready_i,
  input logic [SAMPLE_BITS-1:0]   filtered_o
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_valid_o && !filtered_ready_i |=> filtered_valid_o && $stable(filtered_o))
    else $error("filtered word dropped or changed while stalled");

  // A draining receiver never backs up the sample side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_ready_i |-> sample_ready_o)
    else $error("sample_ready_o low while filtered side drains");

  // After a sample is taken, the block either has room or has a result to show
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> sample_ready_o || filtered_valid_o)
    else $error("input blocked with no result pending");

  // A result only appears after a sample went in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(filtered_valid_o) |-> $past(!sample_ready_o || sample_valid_i, 2)
                                || $past(sample_valid_i && sample_ready_o, 1)
                                || $past(!sample_ready_o, 1))
    else $error("filtered word without a sample");

endmodule

bind ema_deadband_filter_unit edf_checker u_edf_checker (.*);
